// ===== hw/rtl/lkvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Field widths, operation codes and the control/status structs that pass
// between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [KEY_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // scan unit control
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    // scan unit status
    typedef struct packed {
        logic hit;
        logic free_found;
        logic any_valid;
    } scan_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Get/set transactions on a 32-bit key. A sequencer walks the entry memory
// with one shared compare unit, then makes a second pass to update ranks.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    op, key, write_value
//   out      out_valid / out_ready  found, read_value, evicted
//   cfg      cfg_valid / cfg_ready  capacity_limit
//
// A get miss makes only the first pass; any other transaction makes both
// passes over the single read port of the entry memory.
// in_ready is high only in idle; one transaction is in flight at a time.
// A finished result waits in the output register while the next input is taken.
// Reset clears valid bits and occupancy and sets capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    op,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [VAL_W-1:0]        write_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         found,
    output logic signed [KEY_W-1:0]      read_value,
    output logic                         evicted,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CAP_W-1:0]        capacity_limit
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int MEM_W  = KEY_W + VAL_W + RANK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PROMOTE,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [RANK_W-1:0]   old_rank_reg, old_rank_next;
    logic                age_all_reg, age_all_next;
    logic                evict_reg, evict_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [KEY_W-1:0]    read_value_reg, read_value_next;
    logic                evicted_reg, evicted_next;

    logic                issue;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [MEM_W-1:0]    mem_wdata;
    logic [MEM_W-1:0]    mem_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_val;
    logic [RANK_W-1:0]   rd_rank;
    logic                full;
    logic [CAP_W-1:0]    lim;

    scan_ctl_t           scan_ctl;
    scan_flags_t         scan_flags;
    logic [IDX_W-1:0]    hit_idx;
    logic [RANK_W-1:0]   hit_rank;
    logic [VAL_W-1:0]    hit_val;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    oldest_idx;
    logic [RANK_W-1:0]   oldest_rank;

    assign rd_key  = mem_rdata[MEM_W-1 -: KEY_W];
    assign rd_val  = mem_rdata[RANK_W +: VAL_W];
    assign rd_rank = mem_rdata[RANK_W-1:0];

    // capacity 0 acts as 1, anything above ENTRIES acts as ENTRIES
    assign lim  = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign full = (CMP_W'(occ_reg) >= CMP_W'(lim)) || (occ_reg == CNT_W'(ENTRIES));

    lkvc_entry_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (MEM_W),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pend_idx_reg),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    lkvc_scan #(
        .IDX_W  (IDX_W),
        .RANK_W (RANK_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .idx         (pend_idx_reg),
        .entry_valid (valid_reg[pend_idx_reg]),
        .entry_key   (rd_key),
        .entry_val   (rd_val),
        .entry_rank  (rd_rank),
        .key         (key_reg),
        .flags       (scan_flags),
        .hit_idx     (hit_idx),
        .hit_rank    (hit_rank),
        .hit_val     (hit_val),
        .free_idx    (free_idx),
        .oldest_idx  (oldest_idx),
        .oldest_rank (oldest_rank)
    );

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        old_rank_next   = old_rank_reg;
        age_all_next    = age_all_reg;
        evict_next      = evict_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        read_value_next = read_value_reg;
        evicted_next    = evicted_reg;
        scan_ctl        = '0;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        issue           = 1'b0;
        rd_addr         = '0;

        if (cfg_valid)
        begin
            cap_next = capacity_limit;
        end

        // both passes stream one entry per cycle through the read port
        if (state_reg == S_SCAN || state_reg == S_PROMOTE)
        begin
            issue = (rd_cnt_reg != CNT_W'(ENTRIES));
            if (issue)
            begin
                rd_addr     = rd_cnt_reg[IDX_W-1:0];
                rd_cnt_next = CNT_W'(rd_cnt_reg + 1'b1);
            end
            pend_next     = issue;
            pend_idx_next = rd_addr;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = op;
                    key_next       = key;
                    val_next       = write_value;
                    scan_ctl.clear = 1'b1;
                    rd_cnt_next    = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_ctl.sample = pend_reg;
                if (!issue && pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rd_cnt_next  = '0;
                evict_next   = 1'b0;
                age_all_next = 1'b0;
                state_next   = S_PROMOTE;
                if (scan_flags.hit)
                begin
                    slot_next     = hit_idx;
                    old_rank_next = hit_rank;
                end
                else if (op_reg == OP_SET)
                begin
                    if (!full)
                    begin
                        slot_next            = free_idx;
                        age_all_next         = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        occ_next             = CNT_W'(occ_reg + 1'b1);
                    end
                    else
                    begin
                        slot_next     = oldest_idx;
                        old_rank_next = oldest_rank;
                        evict_next    = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_PROMOTE:
            begin
                if (pend_reg)
                begin
                    if (pend_idx_reg == slot_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {key_reg, (op_reg == OP_SET) ? val_reg : rd_val,
                                     {RANK_W{1'b0}}};
                    end
                    else if (valid_reg[pend_idx_reg] &&
                             (age_all_reg || rd_rank < old_rank_reg))
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_key, rd_val, RANK_W'(rd_rank + 1'b1)};
                    end
                end
                if (!issue && pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = scan_flags.hit;
                    read_value_next = (scan_flags.hit && op_reg == OP_GET) ?
                                      {1'b0, hit_val} : MINUS_ONE;
                    evicted_next    = !scan_flags.hit && op_reg == OP_SET && evict_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            occ_reg       <= '0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        slot_reg       <= slot_next;
        old_rank_reg   <= old_rank_next;
        age_all_reg    <= age_all_next;
        evict_reg      <= evict_next;
        found_reg      <= found_next;
        read_value_reg <= read_value_next;
        evicted_reg    <= evicted_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count out of step with valid bits");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a transaction is in flight");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !found)
        else $error("eviction reported on a hit");

    a_miss_reads_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> read_value == MINUS_ONE)
        else $error("miss returned a value");

    a_single_write_per_entry: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_PROMOTE && pend_reg)
        else $error("entry memory written outside the update pass");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lkvc_entry_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_entry_mem: entry storage
// One write port, one read port with registered read data. Each word holds
// key, value and recency rank of one entry.
// ----------------------------------------------------------------------------
module lkvc_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 67,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lkvc_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_scan: shared key compare and rank compare unit
// Looks at one entry per sample and accumulates the first key match, the
// first free slot and the oldest valid entry over a pass.
// ----------------------------------------------------------------------------
module lkvc_scan
    import lkvc_pkg::*;
#(
    parameter int IDX_W  = 4,
    parameter int RANK_W = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire logic              entry_valid,
    input  wire logic [KEY_W-1:0]  entry_key,
    input  wire logic [VAL_W-1:0]  entry_val,
    input  wire logic [RANK_W-1:0] entry_rank,
    input  wire logic [KEY_W-1:0]  key,
    output scan_flags_t            flags,
    output logic [IDX_W-1:0]       hit_idx,
    output logic [RANK_W-1:0]      hit_rank,
    output logic [VAL_W-1:0]       hit_val,
    output logic [IDX_W-1:0]       free_idx,
    output logic [IDX_W-1:0]       oldest_idx,
    output logic [RANK_W-1:0]      oldest_rank
);

    scan_flags_t        flags_reg, flags_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0]  hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0]   hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [RANK_W-1:0]  oldest_rank_reg, oldest_rank_next;
    logic               match;

    assign match = entry_valid && (entry_key == key);

    always_comb
    begin
        flags_next       = flags_reg;
        hit_idx_next     = hit_idx_reg;
        hit_rank_next    = hit_rank_reg;
        hit_val_next     = hit_val_reg;
        free_idx_next    = free_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_rank_next = oldest_rank_reg;
        if (ctl.clear)
        begin
            flags_next = '0;
        end
        else if (ctl.sample)
        begin
            if (match && !flags_reg.hit)
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = idx;
                hit_rank_next  = entry_rank;
                hit_val_next   = entry_val;
            end
            if (!entry_valid && !flags_reg.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_idx_next         = idx;
            end
            if (entry_valid && (!flags_reg.any_valid || entry_rank > oldest_rank_reg))
            begin
                flags_next.any_valid = 1'b1;
                oldest_idx_next      = idx;
                oldest_rank_next     = entry_rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg     <= hit_idx_next;
        hit_rank_reg    <= hit_rank_next;
        hit_val_reg     <= hit_val_next;
        free_idx_reg    <= free_idx_next;
        oldest_idx_reg  <= oldest_idx_next;
        oldest_rank_reg <= oldest_rank_next;
    end

    assign flags       = flags_reg;
    assign hit_idx     = hit_idx_reg;
    assign hit_rank    = hit_rank_reg;
    assign hit_val     = hit_val_reg;
    assign free_idx    = free_idx_reg;
    assign oldest_idx  = oldest_idx_reg;
    assign oldest_rank = oldest_rank_reg;

endmodule
`default_nettype wire
